// ===== hw/rtl/ubfh_pkg.sv =====
`timescale 1ns / 1ps

package ubfh_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ACTIVATE = 4'd1,
        PH_ERASE    = 4'd2,
        PH_FILL     = 4'd3,
        PH_WCMD     = 4'd4,
        PH_ADDR     = 4'd5,
        PH_DATA     = 4'd6,
        PH_GO       = 4'd7,
        PH_DONE     = 4'd8,
        PH_FAILED   = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_REPLY   = 3'd1,
        CMD_FW_BYTE = 3'd2,
        CMD_TX_SLOT = 3'd3,
        CMD_TIMEOUT = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_NACK       = 3'd1,
        ERR_INVALID    = 3'd2,
        ERR_TIMEOUT    = 3'd3,
        ERR_MISALIGNED = 3'd4
    } err_t;

    localparam logic       REG_FLASH_BASE   = 1'b0;
    localparam logic       REG_JUMP_ADDRESS = 1'b1;

    localparam logic [7:0]  BYTE_ACTIVATE = 8'h7F;
    localparam logic [7:0]  BYTE_ACK      = 8'h79;
    localparam logic [7:0]  BYTE_NACK     = 8'h1F;
    localparam logic [7:0]  BYTE_WRITE    = 8'h31;
    localparam logic [7:0]  BYTE_WRITE_N  = 8'hCE;
    localparam logic [7:0]  BYTE_ERASE    = 8'h44;
    localparam logic [7:0]  BYTE_ERASE_N  = 8'hBB;
    localparam logic [7:0]  BYTE_GO       = 8'h21;
    localparam logic [7:0]  BYTE_GO_N     = 8'hDE;
    localparam logic [7:0]  BYTE_PAD      = 8'hFF;
    localparam logic [31:0] DEFAULT_ADDR  = 32'h0800_0000;

    // Extended erase command followed by the mass-erase code and their XOR.
    function automatic logic [7:0] erase_byte(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = BYTE_ERASE;
            3'd1:    b = BYTE_ERASE_N;
            3'd2:    b = 8'hFF;
            3'd3:    b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Big-endian address bytes, then their XOR.
    function automatic logic [7:0] addr_frame_byte(input logic [31:0] a, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = a[31:24];
            3'd1:    b = a[23:16];
            3'd2:    b = a[15:8];
            3'd3:    b = a[7:0];
            default: b = a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/uart_bootloader_flash_host.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                  Contents
// s_        input      tdata, tuser, tlast    byte_value, cmd + end_of_image, end_of_block
// m_        output     tdata, tuser           status fields and tx_byte, tx_valid
// cfg_      input      wr_en, index, wdata    flash_base (0), jump_address (1)
//
// One beat is accepted per cycle while results are taken; its result passes through the input
// register, then the result register. The state update is a single pass per beat; the block
// buffer is a memory whose next read address is prefetched from the next-state send index.
// Reset is synchronous and clears control state only; the buffer is never cleared.
// A stalled result holds in the result register while one more beat waits in the input
// register; only then does s_tready drop.

module uart_bootloader_flash_host
    import ubfh_pkg::*;
#(
    parameter int BLOCK_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [3:0]  s_tuser,   // [2:0] cmd, [3] end_of_image
    input  logic        s_tlast,   // end_of_block

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] tx_byte, [8] data_accepted, [9] ready_for_data,
                                   // [13:10] session_phase, [16:14] error_code, rest zero
    output logic        m_tuser,   // tx_valid

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int AW      = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int CW      = $clog2(BLOCK_BYTES + 1);
    localparam int PAD_MAX = ((BLOCK_BYTES + 3) / 4) * 4;
    localparam int SI_W    = ($clog2(PAD_MAX + 3) > 3) ? $clog2(PAD_MAX + 3) : 3;

    // Handshake and input register
    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eob_reg;
    logic        in_eoi_reg;
    logic        s_accept;
    logic        proc;

    // Configuration
    logic [31:0] flash_base_reg;
    logic [31:0] jump_address_reg;

    // Session state
    phase_t          phase_reg, phase_next;
    logic            await_reg, await_next;
    logic [CW-1:0]   block_count_reg, block_count_next;
    logic [SI_W-1:0] send_index_reg, send_index_next;
    logic [7:0]      check_reg, check_next;
    logic [31:0]     write_ptr_reg, write_ptr_next;
    logic            image_done_reg, image_done_next;
    err_t            fault_reg, fault_next;

    // Block buffer
    logic [7:0]      block_mem [BLOCK_BYTES];
    logic [7:0]      mem_q_reg;
    logic            mem_we;
    logic [AW-1:0]   rd_addr;

    // Result register
    logic            m_valid_reg;
    logic            tx_valid_reg, tx_valid_next;
    logic [7:0]      tx_byte_reg, tx_byte_next;
    logic            accepted_reg, accepted_next;

    // Data-frame helpers
    logic [SI_W-1:0] pad_sum;
    logic [SI_W-1:0] padded;
    logic [SI_W-1:0] pos;
    logic [7:0]      data_byte;
    logic [CW-1:0]   bc_inc;

    assign s_accept = s_tvalid && s_tready;
    assign proc     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg  <= cmd_t'(s_tuser[2:0]);
            in_byte_reg <= s_tdata;
            in_eob_reg  <= s_tlast;
            in_eoi_reg  <= s_tuser[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_base_reg   <= DEFAULT_ADDR;
            jump_address_reg <= DEFAULT_ADDR;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FLASH_BASE:   flash_base_reg   <= cfg_wdata;
                REG_JUMP_ADDRESS: jump_address_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign pad_sum   = SI_W'(block_count_reg) + SI_W'(3);
    assign padded    = {pad_sum[SI_W-1:2], 2'b00};
    assign pos       = send_index_reg - SI_W'(1);
    assign data_byte = (pos < SI_W'(block_count_reg)) ? mem_q_reg : BYTE_PAD;
    assign bc_inc    = block_count_reg + CW'(1);

    always_comb begin
        phase_next       = phase_reg;
        await_next       = await_reg;
        block_count_next = block_count_reg;
        send_index_next  = send_index_reg;
        check_next       = check_reg;
        write_ptr_next   = write_ptr_reg;
        image_done_next  = image_done_reg;
        fault_next       = fault_reg;
        tx_valid_next    = 1'b0;
        tx_byte_next     = 8'h00;
        accepted_next    = 1'b0;
        mem_we           = 1'b0;

        if (proc) begin
            case (in_cmd_reg)
                CMD_START: begin
                    if (phase_reg == PH_IDLE || phase_reg == PH_DONE
                            || phase_reg == PH_FAILED) begin
                        phase_next       = PH_ACTIVATE;
                        await_next       = 1'b0;
                        block_count_next = '0;
                        send_index_next  = '0;
                        check_next       = 8'h00;
                        write_ptr_next   = flash_base_reg;
                        image_done_next  = 1'b0;
                        fault_next       = ERR_NONE;
                    end
                end
                CMD_REPLY: begin
                    if (await_reg) begin
                        await_next = 1'b0;
                        if (in_byte_reg == BYTE_ACK) begin
                            case (phase_reg)
                                PH_ACTIVATE: begin
                                    phase_next      = PH_ERASE;
                                    send_index_next = '0;
                                end
                                PH_ERASE: begin
                                    if (send_index_reg >= SI_W'(5)) begin
                                        phase_next      = PH_FILL;
                                        send_index_next = '0;
                                    end
                                end
                                PH_WCMD: begin
                                    phase_next      = PH_ADDR;
                                    send_index_next = '0;
                                end
                                PH_ADDR: begin
                                    phase_next      = PH_DATA;
                                    send_index_next = '0;
                                end
                                PH_DATA: begin
                                    write_ptr_next   = write_ptr_reg + 32'(block_count_reg);
                                    block_count_next = '0;
                                    send_index_next  = '0;
                                    phase_next       = image_done_reg ? PH_GO : PH_FILL;
                                end
                                PH_GO: begin
                                    if (send_index_reg >= SI_W'(7)) begin
                                        phase_next = PH_DONE;
                                    end
                                end
                                default: ;
                            endcase
                        end else begin
                            phase_next = PH_FAILED;
                            fault_next = (in_byte_reg == BYTE_NACK) ? ERR_NACK : ERR_INVALID;
                        end
                    end
                end
                CMD_FW_BYTE: begin
                    if (phase_reg == PH_FILL && block_count_reg < CW'(BLOCK_BYTES)) begin
                        mem_we           = 1'b1;
                        block_count_next = bc_inc;
                        accepted_next    = 1'b1;
                        if (in_eoi_reg) begin
                            image_done_next = 1'b1;
                        end
                        if (in_eob_reg || in_eoi_reg || bc_inc >= CW'(BLOCK_BYTES)) begin
                            send_index_next = '0;
                            // A block may only start on a word boundary.
                            if (write_ptr_reg[1:0] != 2'b00) begin
                                phase_next = PH_FAILED;
                                fault_next = ERR_MISALIGNED;
                                await_next = 1'b0;
                            end else begin
                                phase_next = PH_WCMD;
                            end
                        end
                    end
                end
                CMD_TX_SLOT: begin
                    if (!await_reg) begin
                        case (phase_reg)
                            PH_ACTIVATE: begin
                                tx_valid_next   = 1'b1;
                                tx_byte_next    = BYTE_ACTIVATE;
                                send_index_next = SI_W'(1);
                                await_next      = 1'b1;
                            end
                            PH_ERASE: begin
                                if (send_index_reg < SI_W'(5)) begin
                                    tx_valid_next   = 1'b1;
                                    tx_byte_next    = erase_byte(send_index_reg[2:0]);
                                    send_index_next = send_index_reg + SI_W'(1);
                                    await_next      = (send_index_reg == SI_W'(1))
                                                   || (send_index_reg == SI_W'(4));
                                end
                            end
                            PH_WCMD: begin
                                if (send_index_reg < SI_W'(2)) begin
                                    tx_valid_next   = 1'b1;
                                    tx_byte_next    = (send_index_reg == '0) ? BYTE_WRITE
                                                                             : BYTE_WRITE_N;
                                    send_index_next = send_index_reg + SI_W'(1);
                                    await_next      = (send_index_reg == SI_W'(1));
                                end
                            end
                            PH_ADDR: begin
                                if (send_index_reg < SI_W'(5)) begin
                                    tx_valid_next   = 1'b1;
                                    tx_byte_next    = addr_frame_byte(write_ptr_reg,
                                                                      send_index_reg[2:0]);
                                    send_index_next = send_index_reg + SI_W'(1);
                                    await_next      = (send_index_reg == SI_W'(4));
                                end
                            end
                            PH_DATA: begin
                                // Length byte, padded data, then the XOR of all of them.
                                if (send_index_reg <= padded + SI_W'(1)) begin
                                    tx_valid_next = 1'b1;
                                    if (send_index_reg == '0) begin
                                        tx_byte_next = 8'(padded - SI_W'(1));
                                        check_next   = 8'(padded - SI_W'(1));
                                    end else if (send_index_reg <= padded) begin
                                        tx_byte_next = data_byte;
                                        check_next   = check_reg ^ data_byte;
                                    end else begin
                                        tx_byte_next = check_reg;
                                    end
                                    send_index_next = send_index_reg + SI_W'(1);
                                    await_next      = (send_index_reg == padded + SI_W'(1));
                                end
                            end
                            PH_GO: begin
                                if (send_index_reg < SI_W'(7)) begin
                                    tx_valid_next = 1'b1;
                                    if (send_index_reg == '0) begin
                                        tx_byte_next = BYTE_GO;
                                    end else if (send_index_reg == SI_W'(1)) begin
                                        tx_byte_next = BYTE_GO_N;
                                    end else begin
                                        tx_byte_next = addr_frame_byte(jump_address_reg,
                                            send_index_reg[2:0] - 3'd2);
                                    end
                                    send_index_next = send_index_reg + SI_W'(1);
                                    await_next      = (send_index_reg == SI_W'(1))
                                                   || (send_index_reg == SI_W'(6));
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_TIMEOUT: begin
                    if (await_reg) begin
                        phase_next = PH_FAILED;
                        fault_next = ERR_TIMEOUT;
                        await_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            await_reg       <= 1'b0;
            block_count_reg <= '0;
            send_index_reg  <= '0;
            check_reg       <= 8'h00;
            write_ptr_reg   <= 32'h0;
            image_done_reg  <= 1'b0;
            fault_reg       <= ERR_NONE;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            await_reg       <= await_next;
            block_count_reg <= block_count_next;
            send_index_reg  <= send_index_next;
            check_reg       <= check_next;
            write_ptr_reg   <= write_ptr_next;
            image_done_reg  <= image_done_next;
            fault_reg       <= fault_next;
            if (proc) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            accepted_reg <= accepted_next;
        end
    end

    // The read address follows the next send index, so the data byte a transmit
    // slot needs is already in mem_q_reg when that slot is processed.
    assign rd_addr = AW'(send_index_next - SI_W'(1));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            block_mem[block_count_reg[AW-1:0]] <= in_byte_reg;
        end
        mem_q_reg <= block_mem[rd_addr];
    end

    // Phase and fault in the result are the state after the beat.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = tx_valid_reg;
    assign m_tdata  = {7'd0, fault_reg, phase_reg, (phase_reg == PH_FILL), accepted_reg,
                       tx_byte_reg};

    a_await_in_session: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg |-> (phase_reg >= PH_ACTIVATE && phase_reg <= PH_GO))
        else $error("reply awaited outside an active session");

    a_fault_only_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_reg != ERR_NONE |-> phase_reg == PH_FAILED)
        else $error("error code set while not in the failed phase");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        block_count_reg <= CW'(BLOCK_BYTES))
        else $error("block count beyond buffer size");

    a_tx_in_session: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && tx_valid_next |=> phase_reg != PH_IDLE && phase_reg != PH_FILL)
        else $error("byte transmitted while idle or filling");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ubfh_pkg::*;

    localparam int          BLOCK_CAP    = 256;
    localparam int          PHASE_BEATS  = 220;
    localparam int          CYCLE_LIMIT  = 400_000;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [15:0] MASS_ERASE   = 16'hFFFF;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       accepted;
        logic       fill_ready;
        phase_t     phase;
        err_t       err;
    } host_out_t;

    class bootload_scoreboard;
        logic [31:0] flash_base;
        logic [31:0] jump_address;
        phase_t      phase;
        bit          awaiting;
        logic [7:0]  blk_buf [BLOCK_CAP];
        logic [7:0]  erase_seq [5];
        int unsigned fill_count;
        int unsigned tx_idx;
        logic [7:0]  xsum;
        logic [31:0] wptr;
        bit          last_block;
        err_t        fault;
        host_out_t   expected_out [$];
        int unsigned mismatches, results_checked;
        int unsigned sessions_done, sessions_aborted, full_blocks;

        function new();
            flash_base = DEFAULT_ADDR;
            jump_address = DEFAULT_ADDR;
            phase = PH_IDLE;
            awaiting = 1'b0;
            fill_count = 0;
            tx_idx = 0;
            xsum = 8'h00;
            wptr = 32'h0;
            last_block = 1'b0;
            fault = ERR_NONE;
            erase_seq = '{BYTE_ERASE, BYTE_ERASE_N, MASS_ERASE[15:8], MASS_ERASE[7:0],
                          MASS_ERASE[15:8] ^ MASS_ERASE[7:0]};
            mismatches = 0;
            results_checked = 0;
            sessions_done = 0;
            sessions_aborted = 0;
            full_blocks = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_FLASH_BASE)
                flash_base = val;
            else
                jump_address = val;
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        // Address frame: four bytes most significant first, then their XOR.
        function logic [7:0] addr_byte(logic [31:0] a, int unsigned k);
            if (k < 4)
                return 8'(a >> (8 * (3 - k)));
            return a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
        endfunction

        function void abort_session(err_t code);
            phase = PH_FAILED;
            fault = code;
            awaiting = 1'b0;
            sessions_aborted++;
        endfunction

        function void close_block();
            tx_idx = 0;
            if (wptr[1:0] != 2'b00)
                abort_session(ERR_MISALIGNED);
            else
                phase = PH_WCMD;
        endfunction

        function void take_ack();
            awaiting = 1'b0;
            case (phase)
                PH_ACTIVATE: begin
                    phase = PH_ERASE;
                    tx_idx = 0;
                end
                PH_ERASE: begin
                    if (tx_idx >= 5) begin
                        phase = PH_FILL;
                        tx_idx = 0;
                    end
                end
                PH_WCMD: begin
                    phase = PH_ADDR;
                    tx_idx = 0;
                end
                PH_ADDR: begin
                    phase = PH_DATA;
                    tx_idx = 0;
                end
                PH_DATA: begin
                    if (fill_count == BLOCK_CAP)
                        full_blocks++;
                    wptr += 32'(fill_count);
                    fill_count = 0;
                    tx_idx = 0;
                    phase = last_block ? PH_GO : PH_FILL;
                end
                PH_GO: begin
                    if (tx_idx >= 7) begin
                        phase = PH_DONE;
                        sessions_done++;
                    end
                end
                default: ;
            endcase
        endfunction

        function bit send_slot(output logic [7:0] b);
            int unsigned padded;
            b = 8'h00;
            if (awaiting)
                return 1'b0;
            case (phase)
                PH_ACTIVATE: begin
                    b = BYTE_ACTIVATE;
                    tx_idx = 1;
                    awaiting = 1'b1;
                end
                PH_ERASE: begin
                    if (tx_idx >= 5)
                        return 1'b0;
                    b = erase_seq[tx_idx];
                    tx_idx++;
                    awaiting = (tx_idx == 2 || tx_idx == 5);
                end
                PH_WCMD: begin
                    if (tx_idx >= 2)
                        return 1'b0;
                    b = (tx_idx == 0) ? BYTE_WRITE : BYTE_WRITE_N;
                    tx_idx++;
                    awaiting = (tx_idx == 2);
                end
                PH_ADDR: begin
                    if (tx_idx >= 5)
                        return 1'b0;
                    b = addr_byte(wptr, tx_idx);
                    tx_idx++;
                    awaiting = (tx_idx == 5);
                end
                PH_DATA: begin
                    // Length byte, data padded to whole words, then the XOR of all of them.
                    padded = (fill_count + 3) & ~32'd3;
                    if (tx_idx > padded + 1)
                        return 1'b0;
                    if (tx_idx == 0) begin
                        b = 8'(padded - 1);
                        xsum = b;
                    end else if (tx_idx <= padded) begin
                        b = (tx_idx - 1 < fill_count) ? blk_buf[tx_idx - 1] : BYTE_PAD;
                        xsum ^= b;
                    end else begin
                        b = xsum;
                    end
                    tx_idx++;
                    awaiting = (tx_idx == padded + 2);
                end
                PH_GO: begin
                    if (tx_idx >= 7)
                        return 1'b0;
                    if (tx_idx < 2)
                        b = (tx_idx == 0) ? BYTE_GO : BYTE_GO_N;
                    else
                        b = addr_byte(jump_address, tx_idx - 2);
                    tx_idx++;
                    awaiting = (tx_idx == 2 || tx_idx == 7);
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // Advances the session by one accepted beat and queues the status it should
        // produce. Returns whether the beat changed anything.
        function bit note_beat(logic [2:0] op, logic [7:0] v, bit eob, bit eoi);
            host_out_t o;
            phase_t    prior_phase;
            bit        prior_await;
            logic [7:0] b;
            o = '0;
            prior_phase = phase;
            prior_await = awaiting;
            case (op)
                CMD_START: begin
                    if (phase inside {PH_IDLE, PH_DONE, PH_FAILED}) begin
                        phase = PH_ACTIVATE;
                        awaiting = 1'b0;
                        fill_count = 0;
                        tx_idx = 0;
                        xsum = 8'h00;
                        wptr = flash_base;
                        last_block = 1'b0;
                        fault = ERR_NONE;
                    end
                end
                CMD_REPLY: begin
                    if (awaiting) begin
                        if (v == BYTE_ACK)
                            take_ack();
                        else if (v == BYTE_NACK)
                            abort_session(ERR_NACK);
                        else
                            abort_session(ERR_INVALID);
                    end
                end
                CMD_FW_BYTE: begin
                    if (phase == PH_FILL && fill_count < BLOCK_CAP) begin
                        blk_buf[fill_count] = v;
                        fill_count++;
                        o.accepted = 1'b1;
                        if (eoi)
                            last_block = 1'b1;
                        if (eob || eoi || fill_count >= BLOCK_CAP)
                            close_block();
                    end
                end
                CMD_TX_SLOT: begin
                    o.tx_valid = send_slot(b);
                    o.tx_byte = o.tx_valid ? b : 8'h00;
                end
                CMD_TIMEOUT: begin
                    if (awaiting)
                        abort_session(ERR_TIMEOUT);
                end
                default: ;
            endcase
            o.fill_ready = (phase == PH_FILL);
            o.phase = phase;
            o.err = fault;
            expected_out.push_back(o);
            return o.tx_valid || o.accepted || phase != prior_phase || awaiting != prior_await;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_beat(logic [23:0] d, logic u);
            host_out_t e;
            results_checked++;
            if (expected_out.size() == 0) begin
                flag($sformatf("unexpected result beat: tdata=%06h tuser=%0b", d, u));
                return;
            end
            e = expected_out.pop_front();
            if (u !== e.tx_valid || d[7:0] !== e.tx_byte || d[8] !== e.accepted ||
                d[9] !== e.fill_ready || d[13:10] !== e.phase || d[16:14] !== e.err)
                flag($sformatf({"result %0d mismatch: expected tx_valid=%0b tx=%02h acc=%0b",
                                " rdy=%0b phase=%0d err=%0d, got tx_valid=%0b tx=%02h acc=%0b",
                                " rdy=%0b phase=%0d err=%0d"},
                               results_checked, e.tx_valid, e.tx_byte, e.accepted,
                               e.fill_ready, e.phase, e.err, u, d[7:0], d[8], d[9],
                               d[13:10], d[16:14]));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [3:0]  s_tuser;   // [2:0] cmd, [3] end_of_image
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] tx_byte, [8] data_accepted, [9] ready_for_data,
                            // [13:10] session_phase, [16:14] error_code
    logic        m_tuser;   // tx_valid
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    bootload_scoreboard sb;
    int          idle_pct;
    int unsigned cycle_count;
    int unsigned beats_sent, useful_beats;
    int unsigned blk_target, blocks_left;
    bit          force_full;

    uart_bootloader_flash_host #(
        .BLOCK_BYTES (BLOCK_CAP)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tuser);
    end

    task automatic send_beat(input logic [2:0] op, input logic [7:0] v, input bit eob,
                             input bit eoi);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tuser <= {eoi, op};
        s_tlast <= eob;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (sb.note_beat(op, v, eob, eoi))
            useful_beats++;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic settle();
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Plays the target side: mostly acknowledges frames and feeds well-formed images,
    // with a little noise and the odd rejected or timed-out frame.
    task automatic drive_session_beat();
        logic [2:0]  op;
        logic [7:0]  v;
        bit          eob, eoi;
        int unsigned r;
        v = 8'($urandom);
        eob = 1'b0;
        eoi = 1'b0;
        op = CMD_TX_SLOT;
        r = $urandom_range(99);
        if (r < 5) begin
            op = 3'($urandom);
            eob = 1'($urandom);
            eoi = 1'($urandom);
        end else if (sb.phase inside {PH_IDLE, PH_DONE, PH_FAILED}) begin
            if (r < 75) begin
                op = CMD_START;
                blocks_left = $urandom_range(1, 4);
            end
        end else if (sb.awaiting) begin
            if (r < 93) begin
                op = CMD_REPLY;
                v = BYTE_ACK;
            end else if (r < 95) begin
                op = CMD_TX_SLOT;
            end else if (r < 96) begin
                op = CMD_TIMEOUT;
            end else if (r < 97) begin
                op = CMD_REPLY;
                v = BYTE_NACK;
            end else if (r < 98) begin
                op = CMD_REPLY;
            end else begin
                op = CMD_START;
            end
        end else if (sb.phase == PH_FILL) begin
            if (r < 88) begin
                op = CMD_FW_BYTE;
                if (sb.fill_count == 0) begin
                    if (force_full || $urandom_range(29) == 0) begin
                        blk_target = BLOCK_CAP;
                        force_full = 1'b0;
                    end else if ($urandom_range(3) != 0) begin
                        blk_target = 4 * $urandom_range(1, 3);
                    end else begin
                        blk_target = $urandom_range(1, 11);
                    end
                end
                if (sb.fill_count + 1 >= blk_target) begin
                    // A full buffer closes itself, so the block marker is optional there.
                    eob = (blk_target < BLOCK_CAP) ? 1'b1 : 1'($urandom);
                    eoi = (blocks_left <= 1);
                    if (eoi)
                        eob = 1'($urandom);
                    if (blocks_left > 0)
                        blocks_left--;
                end
            end else if (r < 92) begin
                op = CMD_TX_SLOT;
            end else if (r < 96) begin
                op = CMD_REPLY;
            end else begin
                op = CMD_TIMEOUT;
            end
        end else begin
            if (r < 90)
                op = CMD_TX_SLOT;
            else if (r < 93)
                op = CMD_REPLY;
            else if (r < 96)
                op = CMD_TIMEOUT;
            else
                op = CMD_FW_BYTE;
        end
        send_beat(op, v, eob, eoi);
    endtask

    initial begin
        sb = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tuser <= 4'h0;
        s_tlast <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_FLASH_BASE;
        cfg_wdata <= 32'h0;
        idle_pct = 20;
        beats_sent = 0;
        useful_beats = 0;
        blk_target = 4;
        blocks_left = 2;
        force_full = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle: empty transmit slots, stray replies, timeouts, firmware bytes and an unused command do nothing.
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_REPLY, BYTE_ACK, 1'b0, 1'b0);
        send_beat(CMD_TIMEOUT, 8'hFF, 1'b1, 1'b1);
        send_beat(CMD_FW_BYTE, 8'hFF, 1'b1, 1'b1);
        send_beat(CMD_SPARE_HI, 8'hFF, 1'b1, 1'b1);
        // Timeout on the activation reply; a start in mid-session is ignored; then a NACK and an invalid reply.
        send_beat(CMD_START, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_START, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_TIMEOUT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_START, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_REPLY, BYTE_NACK, 1'b0, 1'b0);
        send_beat(CMD_START, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_REPLY, 8'h00, 1'b0, 1'b0);
        // A clean activation and erase, leaving the block ready for firmware.
        send_beat(CMD_START, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_REPLY, BYTE_ACK, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_REPLY, BYTE_ACK, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
        send_beat(CMD_REPLY, BYTE_ACK, 1'b0, 1'b0);

        for (int p = 0; p < 6; p++) begin
            if (p != 0) begin
                s_tvalid <= 1'b0;
                settle();
                case (p)
                    1: begin
                        write_reg(REG_FLASH_BASE, 32'h0000_0000);
                        write_reg(REG_JUMP_ADDRESS, 32'hFFFF_FFFF);
                    end
                    2: begin
                        // Base near the top so the write pointer wraps.
                        write_reg(REG_FLASH_BASE, 32'hFFFF_FFFC);
                        write_reg(REG_JUMP_ADDRESS, 32'h0000_0000);
                        force_full = 1'b1;
                    end
                    3: begin
                        write_reg(REG_FLASH_BASE, 32'h0000_0002);
                        write_reg(REG_JUMP_ADDRESS, 32'($urandom));
                    end
                    4: begin
                        write_reg(REG_FLASH_BASE, 32'($urandom) & ~32'd3);
                        write_reg(REG_JUMP_ADDRESS, 32'($urandom));
                    end
                    default: begin
                        write_reg(REG_FLASH_BASE, DEFAULT_ADDR);
                        write_reg(REG_JUMP_ADDRESS, 32'($urandom));
                    end
                endcase
            end
            idle_pct = (p == 3) ? 0 : 20;
            while (useful_beats < (p + 1) * PHASE_BEATS)
                drive_session_beat();
        end
        s_tvalid <= 1'b0;
        settle();

        $display("Drove %0d beats (%0d with effect) and checked %0d result beats.",
                 beats_sent, useful_beats, sb.results_checked);
        $display("Sessions: %0d completed, %0d aborted, %0d full-size blocks; %0d mismatches.",
                 sb.sessions_done, sb.sessions_aborted, sb.full_blocks, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
